[rtl/core/mmn_pkg.sv]
// Shared types and constants for the min-max normalizer.
`default_nettype none
package mmn_pkg;

  localparam int SampleW = 16;
  localparam int NormW   = 17;
  localparam int QuotW   = 16;
  localparam int StepW   = 4;
  localparam logic [StepW-1:0] LastStep = 4'd15;

  localparam logic CmdScan  = 1'b0;
  localparam logic CmdApply = 1'b1;

  localparam logic signed [SampleW-1:0] MinInit = 16'sh7fff;
  localparam logic signed [SampleW-1:0] MaxInit = 16'sh8000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVIDE,
    ST_DONE
  } ctrl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic setup;
    logic step;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic apply;
  } dp_status_t;

endpackage
`default_nettype wire

[rtl/core/mmn_in_if.sv]
// Input channel: command, sample and start flag with valid/ready.
`default_nettype none
interface mmn_in_if import mmn_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic signed [SampleW-1:0]  sample;
  logic                       start_req;

  modport source (output valid, output command, output sample, output start_req,
                  input ready);
  modport sink (input valid, input command, input sample, input start_req,
                output ready);
endinterface
`default_nettype wire

[rtl/core/mmn_out_if.sv]
// Output channel: normalized fraction with valid/ready.
`default_nettype none
interface mmn_out_if import mmn_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [NormW-1:0]   normalized;

  modport source (output valid, output normalized, input ready);
  modport sink (input valid, input normalized, output ready);
endinterface
`default_nettype wire

[rtl/core/mmn_ctrl.sv]
// Controller: sequences scan, divider setup, division steps and output load.
`default_nettype none
module mmn_ctrl import mmn_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  ctrl_state_t      state;
  ctrl_state_t      state_next;
  logic [StepW-1:0] step_cnt;
  logic             out_free;

  assign out_free = !out_valid || out_ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // Take no transaction while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.accept = 1'b1;
          if (status.apply == CmdApply) begin
            state_next = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (step_cnt == LastStep) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Count division steps
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.setup) begin
      step_cnt <= '0;
    end else if (cmd.step) begin
      step_cnt <= step_cnt + 1'b1;
    end
  end

  // Hold the result valid until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[rtl/core/mmn_dp.sv]
// Datapath: running min/max, range checks, radix-2 divider and result register.
`default_nettype none
module mmn_dp import mmn_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       command,
  input  wire logic signed [SampleW-1:0]  sample,
  input  wire logic                       start_req,
  input  wire dp_cmd_t                    cmd,
  output dp_status_t                      status,
  output logic [NormW-1:0]                normalized
);

  logic signed [SampleW-1:0] running_min;
  logic signed [SampleW-1:0] running_max;
  logic signed [SampleW-1:0] base_min;
  logic signed [SampleW-1:0] base_max;
  logic signed [SampleW-1:0] sample_q;
  logic signed [SampleW:0]   diff;
  logic signed [SampleW:0]   range;
  logic [QuotW-1:0]          rem;
  logic [QuotW-1:0]          den;
  logic [QuotW-1:0]          quot;
  logic                      forced;
  logic                      forced_one;
  logic [QuotW:0]            rem_shift;
  logic [QuotW:0]            rem_sub;

  assign status.apply = command;

  // Reset the running bounds first when a scan opens
  assign base_min = start_req ? MinInit : running_min;
  assign base_max = start_req ? MaxInit : running_max;

  // Widen the bounds on every scan sample
  always_ff @(posedge clk) begin
    if (rst) begin
      running_min <= MinInit;
      running_max <= MaxInit;
    end else if (cmd.accept && command == CmdScan) begin
      running_min <= (sample < base_min) ? sample : base_min;
      running_max <= (sample > base_max) ? sample : base_max;
    end
  end

  // Capture the sample to normalize
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_q <= sample;
    end
  end

  assign diff  = {sample_q[SampleW-1], sample_q} - {running_min[SampleW-1], running_min};
  assign range = {running_max[SampleW-1], running_max} - {running_min[SampleW-1], running_min};

  assign rem_shift = {rem, 1'b0};
  assign rem_sub   = rem_shift - {1'b0, den};

  // Set up the divider and flag the saturating cases; then run one bit per step
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      rem        <= diff[QuotW-1:0];
      den        <= range[QuotW-1:0];
      quot       <= '0;
      forced     <= (range <= 0) || (sample_q <= running_min) || (sample_q >= running_max);
      forced_one <= (range > 0) && (sample_q > running_min);
    end else if (cmd.step) begin
      if (!rem_sub[QuotW]) begin
        rem  <= rem_sub[QuotW-1:0];
        quot <= {quot[QuotW-2:0], 1'b1};
      end else begin
        rem  <= rem_shift[QuotW-1:0];
        quot <= {quot[QuotW-2:0], 1'b0};
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      normalized <= forced ? {forced_one, {QuotW{1'b0}}} : {1'b0, quot};
    end
  end

endmodule
`default_nettype wire

[rtl/core/min_max_normalize_top.sv]
// Top level of the min-max normalizer.
//
// Channels: "item" carries command, sample and start_req; "result" carries the
// normalized value as unsigned Q1.16 (65536 is 1.0). Both use valid/ready and
// a transaction completes at a rising edge with valid and ready high.
// A scan transaction (command 0) widens the running minimum and maximum and
// gives no result; start_req on it clears both bounds first. Scan samples
// stream at one per clock while no apply transaction is in progress.
// An apply transaction (command 1) gives one result through a setup step
// for the range checks, the radix-2 divider (one quotient bit per step) and
// a load of the output register once it is free. No new item is taken until
// that result is in the output register.
// Samples at or below the minimum give 0, at or above the maximum 65536; a
// zero or empty range gives 0.
// Reset (rst, synchronous) empties the output register and sets the minimum
// to 32767 and the maximum to -32768.
// A stalled receiver holds the result in the output register; the next item
// is still taken and processed, and its result waits until the register frees.
`default_nettype none
module min_max_normalize_top import mmn_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  mmn_in_if.sink    item,
  mmn_out_if.source result
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mmn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mmn_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .command    (item.command),
    .sample     (item.sample),
    .start_req  (item.start_req),
    .cmd        (cmd),
    .status     (status),
    .normalized (result.normalized)
  );

endmodule
`default_nettype wire
